@@ src/stereo_linked_noise_gate_assert.svh @@
// assertion macros for the stereo linked noise gate
// used by the top level only, no other dependencies
`ifndef STEREO_LINKED_NOISE_GATE_ASSERT_SVH
`define STEREO_LINKED_NOISE_GATE_ASSERT_SVH

// condition implies consequence in the same cycle
`define SLNG_ASSERT_IMPLY(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("slng assertion failed");

// condition implies consequence in the next cycle
`define SLNG_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("slng assertion failed");

`endif

@@ src/slng_pkg.sv @@
// shared constants of the stereo linked noise gate
// no dependencies
`default_nettype none

package slng_pkg;

	// register indexes
	localparam logic [2:0] REG_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_HYSTERESIS = 3'd1;
	localparam logic [2:0] REG_ATTACK = 3'd2;
	localparam logic [2:0] REG_RELEASE = 3'd3;
	localparam logic [2:0] REG_HOLD = 3'd4;
	localparam logic [2:0] REG_BYPASS = 3'd5;
	localparam logic [2:0] REG_DECAY = 3'd6;
	localparam logic [2:0] REG_SMOOTH = 3'd7;

	// item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	localparam logic signed [15:0] THR_LOW = -16'sd20480;
	localparam logic [12:0] HYS_HIGH = 13'd6144;
	localparam logic [18:0] HOLD_HIGH = 19'd384000;
	localparam logic signed [15:0] DB_FLOOR = -16'sd30720;
	localparam logic signed [16:0] DB_PER_LOG2 = 17'sd24660;

	// reset values
	localparam logic signed [15:0] THR_RESET = -16'sd10240;
	localparam logic signed [15:0] HYS_RESET = 16'sd1536;
	localparam logic [31:0] ATTACK_RESET = 32'd65263;
	localparam logic [31:0] RELEASE_RESET = 32'd65522;
	localparam logic [18:0] HOLD_RESET = 19'd2400;
	localparam logic [31:0] DECAY_RESET = 32'd65399;
	localparam logic [31:0] SMOOTH_RESET = 32'd136;

endpackage

`default_nettype wire

@@ src/stereo_linked_noise_gate.sv @@
// stereo linked noise gate: follower, log level, gate with hold, gain glide
// depends on slng_pkg and stereo_linked_noise_gate_assert.svh
//
// channel   group        contents
// input     s_axis_*     tdata left/right sample, tuser item kind
// output    m_axis_*     tdata left/right gated sample, tuser gate state
// config    cfg_*        write enable, index, data
//
// a sample pair steps through glides, decay, normalise, the 8 squaring steps
// of the log on the one shared multiplier, dB, gate, gain and output; a zero
// level skips the log. a clear item goes straight to output. the multiplier
// result is registered and every step uses it once. one request in flight at
// a time; the next is accepted in the cycle after the output register loads,
// and a finished result waits there while the next is accepted.
`default_nettype none

`include "stereo_linked_noise_gate_assert.svh"

module stereo_linked_noise_gate #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEFF_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// left_in, right_in
	input wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	// kind
	input wire logic s_axis_tuser,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// left_out, right_out
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
	// gate_open
	output logic m_axis_tuser,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [((COEFF_BITS > 19) ? COEFF_BITS : 19)-1:0] cfg_data
);
	import slng_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int CB = COEFF_BITS;
	localparam int TDW = ((2*SB+7)/8)*8;
	localparam int AW = ((SB > CB) ? SB : CB) + 2;
	localparam int BW = ((CB > 16) ? CB : 16) + 2;
	localparam int PW = AW + BW;
	localparam int PKW = SB - 1;
	localparam int PBW = $clog2(PKW);
	localparam logic [CB:0] ONE_C = (CB+1)'(1) << CB;
	localparam logic signed [PW-1:0] RND = PW'((64'd1 << CB) - 64'd1);
	localparam logic signed [PW-1:0] SMAX = PW'((64'd1 << (SB-1)) - 64'd1);
	localparam logic signed [PW-1:0] SMIN = -(PW'(64'd1 << (SB-1)));

	typedef enum logic [4:0] {
		ST_IDLE, ST_THR, ST_HYS, ST_WET, ST_DEC, ST_NORM, ST_SQ, ST_SQW, ST_DBM,
		ST_DBC, ST_GATE, ST_GAIN, ST_APPM, ST_LM, ST_RM, ST_FIN, ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic signed [15:0] thr_db_q, hys_db_q;
	logic [CB-1:0] attack_q, release_q, decay_q, smooth_q;
	logic [18:0] hold_len_q;
	logic bypass_q;

	// gate state
	logic [PKW-1:0] peak_q;
	logic [CB:0] gain_q, wet_q, app_q;
	logic signed [15:0] thr_now_q, hys_now_q, db_q;
	logic is_open_q;
	logic [18:0] hold_left_q;

	// working registers
	logic signed [SB-1:0] left_q, right_q, lo_q, ro_q;
	logic [15:0] m_q;
	logic [PBW-1:0] p_q;
	logic [7:0] frac_q;
	logic [2:0] cnt_q;
	logic m_valid_q, gopen_q;

	logic signed [AW-1:0] mul_a;
	logic signed [BW-1:0] mul_b;
	logic signed [PW-1:0] prod_q;

	// derived values
	logic signed [16:0] d_thr, d_hys;
	logic signed [CB+1:0] d_wet;
	logic signed [AW-1:0] gdc;
	logic signed [PW-1:0] gtrunc, gs, sres, sat, db_full;
	logic [PKW-1:0] mag_l, mag_r, pk, decayed, peak_new;
	logic [PBW-1:0] p_c;
	logic [PKW+15:0] nv;
	logic [16:0] sq;
	logic signed [PBW:0] pd;
	logic signed [PBW+8:0] l2;
	logic [CB:0] hi_part, gain_c, app_c;
	logic signed [16:0] lower;
	logic s_acc;
	logic out_load;
	logic signed [SB-1:0] in_l, in_r;

	always_comb begin
		in_l = s_axis_tdata[SB-1:0];
		in_r = s_axis_tdata[2*SB-1:SB];
		s_acc = s_axis_tvalid && s_axis_tready;
		out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);
		d_thr = {thr_db_q[15], thr_db_q} - {thr_now_q[15], thr_now_q};
		d_hys = {hys_db_q[15], hys_db_q} - {hys_now_q[15], hys_now_q};
		d_wet = $signed({1'b0, (bypass_q ? '0 : ONE_C)}) - $signed({1'b0, wet_q});
		// glide difference of the step whose product is being consumed
		case (state_q)
			ST_HYS: gdc = AW'(d_thr);
			ST_WET: gdc = AW'(d_hys);
			default: gdc = AW'(d_wet);
		endcase
		gtrunc = (prod_q + (prod_q[PW-1] ? RND : '0)) >>> CB;
		if (gtrunc == '0 && gdc != '0 && smooth_q != '0) begin
			gs = gdc[AW-1] ? -(PW'(1)) : PW'(1);
		end else begin
			gs = gtrunc;
		end
		// magnitudes, most negative saturated
		mag_l = (left_q == SB'(SMIN)) ? PKW'(SMAX) :
			(left_q[SB-1] ? PKW'(-left_q) : PKW'(left_q));
		mag_r = (right_q == SB'(SMIN)) ? PKW'(SMAX) :
			(right_q[SB-1] ? PKW'(-right_q) : PKW'(right_q));
		pk = (mag_r > mag_l) ? mag_r : mag_l;
		decayed = prod_q[CB +: PKW];
		peak_new = (pk > decayed) ? pk : decayed;
		// leading one and mantissa in q1.15
		p_c = '0;
		for (int i = 0; i < PKW; i++) begin
			if (peak_new[i]) p_c = PBW'(i);
		end
		nv = {peak_new, 16'b0} << (PBW'(PKW-1) - p_c);
		sq = prod_q[31:15];
		pd = $signed({1'b0, p_q}) - (PBW+1)'(PKW);
		l2 = {pd, frac_q};
		db_full = prod_q >>> 12;
		lower = {thr_now_q[15], thr_now_q} - {hys_now_q[15], hys_now_q};
		hi_part = prod_q[CB +: CB+1];
		gain_c = is_open_q ? (ONE_C - hi_part) : hi_part;
		app_c = ONE_C - hi_part;
		sres = prod_q >>> CB;
		sat = (sres > SMAX) ? SMAX : ((sres < SMIN) ? SMIN : sres);
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_THR: begin
				mul_a = AW'(d_thr);
				mul_b = BW'($signed({1'b0, smooth_q}));
			end
			ST_HYS: begin
				mul_a = AW'(d_hys);
				mul_b = BW'($signed({1'b0, smooth_q}));
			end
			ST_WET: begin
				mul_a = AW'(d_wet);
				mul_b = BW'($signed({1'b0, smooth_q}));
			end
			ST_DEC: begin
				mul_a = AW'($signed({1'b0, peak_q}));
				mul_b = BW'($signed({1'b0, decay_q}));
			end
			ST_SQ: begin
				mul_a = AW'($signed({1'b0, m_q}));
				mul_b = BW'($signed({1'b0, m_q}));
			end
			ST_DBM: begin
				mul_a = AW'(l2);
				mul_b = BW'(DB_PER_LOG2);
			end
			ST_GAIN: begin
				if (is_open_q) begin
					mul_a = AW'($signed({1'b0, ONE_C - gain_q}));
					mul_b = BW'($signed({1'b0, attack_q}));
				end else begin
					mul_a = AW'($signed({1'b0, gain_q}));
					mul_b = BW'($signed({1'b0, release_q}));
				end
			end
			ST_APPM: begin
				mul_a = AW'($signed({1'b0, wet_q}));
				mul_b = BW'($signed({1'b0, ONE_C - gain_c}));
			end
			ST_LM: begin
				mul_a = AW'(left_q);
				mul_b = BW'($signed({1'b0, app_c}));
			end
			ST_RM: begin
				mul_a = AW'(right_q);
				mul_b = BW'($signed({1'b0, app_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			thr_db_q <= THR_RESET;
			hys_db_q <= HYS_RESET;
			attack_q <= ATTACK_RESET[CB-1:0];
			release_q <= RELEASE_RESET[CB-1:0];
			decay_q <= DECAY_RESET[CB-1:0];
			smooth_q <= SMOOTH_RESET[CB-1:0];
			hold_len_q <= HOLD_RESET;
			bypass_q <= 1'b1;
			peak_q <= '0;
			gain_q <= '0;
			wet_q <= '0;
			app_q <= '0;
			thr_now_q <= THR_RESET;
			hys_now_q <= HYS_RESET;
			db_q <= DB_FLOOR;
			is_open_q <= 1'b0;
			hold_left_q <= '0;
			left_q <= '0;
			right_q <= '0;
			lo_q <= '0;
			ro_q <= '0;
			m_q <= '0;
			p_q <= '0;
			frac_q <= '0;
			cnt_q <= '0;
			m_valid_q <= 1'b0;
			gopen_q <= 1'b0;
			m_axis_tdata <= '0;
		end else begin
			if (out_load) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_THRESHOLD: begin
						if ($signed(cfg_data[15:0]) < THR_LOW) thr_db_q <= THR_LOW;
						else if ($signed(cfg_data[15:0]) > 16'sd0) thr_db_q <= '0;
						else thr_db_q <= cfg_data[15:0];
					end
					REG_HYSTERESIS: begin
						hys_db_q <= (cfg_data[12:0] > HYS_HIGH) ? 16'(HYS_HIGH)
							: 16'(cfg_data[12:0]);
					end
					REG_ATTACK: attack_q <= cfg_data[CB-1:0];
					REG_RELEASE: release_q <= cfg_data[CB-1:0];
					REG_HOLD: begin
						if (cfg_data[18:0] > HOLD_HIGH) begin
							hold_len_q <= HOLD_HIGH;
							if (hold_left_q > HOLD_HIGH) hold_left_q <= HOLD_HIGH;
						end else begin
							hold_len_q <= cfg_data[18:0];
							if (hold_left_q > cfg_data[18:0]) hold_left_q <= cfg_data[18:0];
						end
					end
					REG_BYPASS: bypass_q <= cfg_data[0];
					REG_DECAY: decay_q <= cfg_data[CB-1:0];
					REG_SMOOTH: smooth_q <= cfg_data[CB-1:0];
					default: bypass_q <= bypass_q;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						left_q <= in_l;
						right_q <= in_r;
						if (s_axis_tuser == KIND_CLEAR) begin
							peak_q <= '0;
							gain_q <= '0;
							is_open_q <= 1'b0;
							hold_left_q <= '0;
							lo_q <= '0;
							ro_q <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_THR;
						end
					end
				end
				ST_THR: state_q <= ST_HYS;
				ST_HYS: begin
					thr_now_q <= thr_now_q + gs[15:0];
					state_q <= ST_WET;
				end
				ST_WET: begin
					hys_now_q <= hys_now_q + gs[15:0];
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					wet_q <= wet_q + gs[CB:0];
					state_q <= ST_NORM;
				end
				ST_NORM: begin
					peak_q <= peak_new;
					p_q <= p_c;
					m_q <= nv[PKW+15 -: 16];
					frac_q <= '0;
					cnt_q <= '0;
					if (peak_new == '0) begin
						db_q <= DB_FLOOR;
						state_q <= ST_GATE;
					end else begin
						state_q <= ST_SQ;
					end
				end
				ST_SQ: state_q <= ST_SQW;
				ST_SQW: begin
					// a square of 2.0 or more gives a one bit and a halving
					m_q <= sq[16] ? sq[16:1] : sq[15:0];
					frac_q <= {frac_q[6:0], sq[16]};
					cnt_q <= cnt_q + 3'd1;
					state_q <= (cnt_q == 3'd7) ? ST_DBM : ST_SQ;
				end
				ST_DBM: state_q <= ST_DBC;
				ST_DBC: begin
					db_q <= (db_full < PW'(DB_FLOOR)) ? DB_FLOOR : db_full[15:0];
					state_q <= ST_GATE;
				end
				ST_GATE: begin
					if (is_open_q || db_q >= thr_now_q) begin
						is_open_q <= 1'b1;
						if ({db_q[15], db_q} >= lower) hold_left_q <= hold_len_q;
						else if (hold_left_q != '0) hold_left_q <= hold_left_q - 19'd1;
						else is_open_q <= 1'b0;
					end
					state_q <= ST_GAIN;
				end
				ST_GAIN: state_q <= ST_APPM;
				ST_APPM: begin
					gain_q <= gain_c;
					state_q <= ST_LM;
				end
				ST_LM: begin
					app_q <= app_c;
					state_q <= ST_RM;
				end
				ST_RM: begin
					lo_q <= sat[SB-1:0];
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					ro_q <= sat[SB-1:0];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						m_axis_tdata <= TDW'({ro_q, lo_q});
						gopen_q <= is_open_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser = gopen_q;

	`SLNG_ASSERT_IMPLY(a_thr_range, clk, arst_n, 1'b1, thr_now_q >= THR_LOW && thr_now_q <= 16'sd0)
	`SLNG_ASSERT_IMPLY(a_hold_le_len, clk, arst_n, 1'b1, hold_left_q <= hold_len_q)
	`SLNG_ASSERT_IMPLY(a_gain_le_one, clk, arst_n, 1'b1, gain_q <= ONE_C && wet_q <= ONE_C)
	`SLNG_ASSERT_NEXT(a_clear, clk, arst_n, s_acc && s_axis_tuser == KIND_CLEAR, peak_q == '0 && gain_q == '0 && !is_open_q)

endmodule

`default_nettype wire

@@ tb/slng_checker.sv @@
// checker for the stereo linked noise gate: mirrors the register writes,
// predicts each output request and compares it; depends on slng_pkg
`timescale 1ns / 1ps
`default_nettype none

module slng_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic [47:0] s_axis_tdata,
	input wire logic s_axis_tuser,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [47:0] m_axis_tdata,
	input wire logic m_axis_tuser,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [18:0] cfg_data,
	output int fail_count,
	output int pending
);
	import slng_pkg::*;

	localparam longint UNITY = 64'sd65536;
	localparam longint PEAK_TOP = 64'sd8388607;
	localparam longint SAMPLE_BOTTOM = -64'sd8388608;

	typedef struct packed {
		logic [23:0] left;
		logic [23:0] right;
		logic open;
	} gated_t;

	gated_t gated_q[$];

	// register copies
	longint thr_target, hys_target, hold_len;
	longint attack, release_c, decay, smooth;
	logic bypass_on;

	// gate state
	longint peak, gain, wet, thr_now, hys_now, hold_cnt;
	logic gate_is_open;

	function automatic longint glide_to(longint now, longint target, longint c);
		longint d, stp;
		begin
			d = target - now;
			stp = (d * c) / UNITY;
			if (stp == 0 && d != 0 && c != 0)
				stp = (d > 0) ? 1 : -1;
			return now + stp;
		end
	endfunction

	function automatic longint level_to_db(longint lv);
		longint m, l2, db;
		int p;
		int frac;
		begin
			if (lv == 0)
				return longint'(DB_FLOOR);
			p = 0;
			while (p < 62 && (lv >> (p + 1)) != 0)
				p++;
			m = (p >= 15) ? (lv >> (p - 15)) : (lv << (15 - p));
			frac = 0;
			// eight fraction bits by repeated squaring
			for (int i = 0; i < 8; i++) begin
				m = (m * m) >> 15;
				frac = frac << 1;
				if (m >= 65536) begin
					frac = frac | 1;
					m = m >> 1;
				end
			end
			l2 = longint'(p - 23) * 256 + frac;
			db = (l2 * 24660) >>> 12;
			if (db < longint'(DB_FLOOR))
				db = longint'(DB_FLOOR);
			return db;
		end
	endfunction

	function automatic longint mag(longint s);
		longint a;
		begin
			a = (s < 0) ? -s : s;
			return (a > PEAK_TOP) ? PEAK_TOP : a;
		end
	endfunction

	function automatic logic [23:0] scaled(longint s, longint applied);
		longint r;
		begin
			r = (s * applied) >>> 16;
			if (r > PEAK_TOP)
				r = PEAK_TOP;
			if (r < SAMPLE_BOTTOM)
				r = SAMPLE_BOTTOM;
			return r[23:0];
		end
	endfunction

	task automatic reset_model();
		thr_target = -10240;
		hys_target = 1536;
		attack = 65263;
		release_c = 65522;
		hold_len = 2400;
		bypass_on = 1'b1;
		decay = 65399;
		smooth = 136;
		peak = 0;
		gain = 0;
		wet = 0;
		thr_now = -10240;
		hys_now = 1536;
		gate_is_open = 1'b0;
		hold_cnt = 0;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [18:0] val);
		longint s;
		begin
			case (idx)
				REG_THRESHOLD: begin
					s = longint'($signed(val[15:0]));
					thr_target = (s < longint'(THR_LOW)) ? longint'(THR_LOW) : ((s > 0) ? 0 : s);
				end
				REG_HYSTERESIS: hys_target = (val[12:0] > HYS_HIGH) ? HYS_HIGH : val[12:0];
				REG_ATTACK: attack = val[15:0];
				REG_RELEASE: release_c = val[15:0];
				REG_HOLD: begin
					hold_len = (val > HOLD_HIGH) ? HOLD_HIGH : val;
					if (hold_cnt > hold_len)
						hold_cnt = hold_len;
				end
				REG_BYPASS: bypass_on = val[0];
				REG_DECAY: decay = val[15:0];
				REG_SMOOTH: smooth = val[15:0];
				default: ;
			endcase
		end
	endtask

	function automatic gated_t gate_step(logic kind, logic [23:0] lin, logic [23:0] rin);
		gated_t g;
		longint l, r, pk, decayed, applied, db;
		begin
			if (kind == KIND_CLEAR) begin
				peak = 0;
				gain = 0;
				gate_is_open = 1'b0;
				hold_cnt = 0;
				g = '0;
				return g;
			end
			thr_now = glide_to(thr_now, thr_target, smooth);
			hys_now = glide_to(hys_now, hys_target, smooth);
			wet = glide_to(wet, bypass_on ? 0 : UNITY, smooth);
			l = longint'($signed(lin));
			r = longint'($signed(rin));
			pk = mag(l);
			if (mag(r) > pk)
				pk = mag(r);
			decayed = (peak * decay) >> 16;
			peak = (pk > decayed) ? pk : decayed;
			db = level_to_db(peak);
			if (!gate_is_open && db >= thr_now)
				gate_is_open = 1'b1;
			if (gate_is_open) begin
				if (db >= thr_now - hys_now)
					hold_cnt = hold_len;
				else if (hold_cnt > 0)
					hold_cnt--;
				else
					gate_is_open = 1'b0;
			end
			if (gate_is_open)
				gain = UNITY - (((UNITY - gain) * attack) >> 16);
			else
				gain = (gain * release_c) >> 16;
			applied = UNITY - ((wet * (UNITY - gain)) >> 16);
			g.left = scaled(l, applied);
			g.right = scaled(r, applied);
			g.open = gate_is_open;
			return g;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gated_t want, got;
		if (!arst_n) begin
			reset_model();
			gated_q.delete();
			fail_count <= 0;
		end else begin
			if (cfg_we)
				write_reg(cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready)
				gated_q.push_back(gate_step(s_axis_tuser, s_axis_tdata[23:0],
					s_axis_tdata[47:24]));
			if (m_axis_tvalid && m_axis_tready) begin
				got.left = m_axis_tdata[23:0];
				got.right = m_axis_tdata[47:24];
				got.open = m_axis_tuser;
				if (gated_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected output request: %h %h %b",
							got.left, got.right, got.open);
					fail_count <= fail_count + 1;
				end else begin
					want = gated_q.pop_front();
					if (want != got) begin
						if (fail_count < 10)
							$display("output mismatch: expected %h %h %b, got %h %h %b",
								want.left, want.right, want.open,
								got.left, got.right, got.open);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

	assign pending = gated_q.size();

endmodule

`default_nettype wire

@@ tb/tb_stereo_linked_noise_gate.sv @@
// stimulus and verdict for the stereo linked noise gate
// depends on slng_pkg, the gate itself and slng_checker
`timescale 1ns / 1ps
`default_nettype none

module tb_stereo_linked_noise_gate;
	import slng_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE = 40;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [18:0] cfg_data;

	int fail_count, pending;
	int idle_cycles;
	int long_stall_req, long_stall_done;

	stereo_linked_noise_gate dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	slng_checker monitor (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// receiver: stall pattern in windows, plus one long hold-off on request
	initial begin
		int mode;
		m_axis_tready <= 1'b0;
		long_stall_done = 0;
		forever begin
			mode = $urandom_range(0, 3);
			for (int i = 0; i < 64; i++) begin
				@(posedge clk);
				if (long_stall_req != long_stall_done) begin
					m_axis_tready <= 1'b0;
					repeat (300) @(posedge clk);
					long_stall_done = long_stall_req;
				end
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= $urandom_range(0, 1);
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// watchdog on cycles with no accepted request
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// one pair per call; valid stays high while the burst continues
	task automatic send_pair(logic kind, logic [23:0] l, logic [23:0] r, bit keep);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {r, l};
		do @(posedge clk); while (!s_axis_tready);
		if (!keep)
			s_axis_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(logic [2:0] idx, logic [18:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [23:0] sample_of(int amp_class);
		logic [23:0] v;
		case (amp_class)
			0: v = 24'd0;
			1: v = 24'($urandom_range(0, 255));
			2: v = 24'($urandom_range(0, 1 << 14));
			3: v = 24'($urandom_range(0, 1 << 19));
			4: v = 24'($urandom_range(0, 24'h7fffff));
			default: v = 24'($urandom);
		endcase
		if (amp_class != 5 && $urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	task automatic phase_config(int ph);
		case (ph)
			1: begin
				write_cfg(REG_THRESHOLD, 19'h08000);
				write_cfg(REG_HYSTERESIS, 19'd0);
				write_cfg(REG_ATTACK, 19'd0);
				write_cfg(REG_RELEASE, 19'd0);
				write_cfg(REG_HOLD, 19'd0);
				write_cfg(REG_BYPASS, 19'd0);
				write_cfg(REG_DECAY, 19'd0);
				write_cfg(REG_SMOOTH, 19'd65535);
			end
			2: begin
				write_cfg(REG_THRESHOLD, 19'h07fff);
				write_cfg(REG_HYSTERESIS, 19'h1fff);
				write_cfg(REG_ATTACK, 19'd65535);
				write_cfg(REG_RELEASE, 19'd65535);
				write_cfg(REG_HOLD, 19'h7ffff);
				write_cfg(REG_BYPASS, 19'd1);
				write_cfg(REG_DECAY, 19'd65535);
				write_cfg(REG_SMOOTH, 19'd0);
			end
			default: begin
				// upper bits random so that only the low bits may count
				write_cfg(REG_THRESHOLD, {3'($urandom),
					16'(-$urandom_range(2048, 18000))});
				write_cfg(REG_HYSTERESIS, 19'($urandom_range(0, 8191)));
				write_cfg(REG_ATTACK, 19'($urandom));
				write_cfg(REG_RELEASE, 19'($urandom));
				write_cfg(REG_HOLD, ($urandom_range(0, 9) == 0) ?
					19'($urandom) : 19'($urandom_range(0, 60)));
				write_cfg(REG_BYPASS, 19'($urandom));
				write_cfg(REG_DECAY, 19'($urandom_range(0, 3) == 0 ?
					$urandom : $urandom_range(60000, 65535)));
				write_cfg(REG_SMOOTH, 19'($urandom_range(0, 1) ?
					$urandom : $urandom_range(0, 2000)));
			end
		endcase
	endtask

	initial begin
		int run_left, amp, burst, sent;
		logic kind;
		arst_n = 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= KIND_SAMPLE;
		cfg_we <= 1'b0;
		cfg_index <= REG_THRESHOLD;
		cfg_data <= '0;
		long_stall_req = 0;
		idle_cycles = 0;
		repeat (3) @(posedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed: extremes, silence, loud bursts, clear
		send_pair(KIND_SAMPLE, 24'd0, 24'd0, 1);
		send_pair(KIND_SAMPLE, 24'h7fffff, 24'h7fffff, 1);
		send_pair(KIND_SAMPLE, 24'h800000, 24'h800000, 1);
		send_pair(KIND_SAMPLE, 24'h800000, 24'h000001, 0);
		send_pair(KIND_SAMPLE, 24'hffffff, 24'h7fffff, 1);
		send_pair(KIND_SAMPLE, 24'h000001, 24'h800001, 1);
		for (int i = 0; i < 8; i++)
			send_pair(KIND_SAMPLE, 24'h400000, 24'hc00000, 1);
		for (int i = 0; i < 6; i++)
			send_pair(KIND_SAMPLE, 24'd3, 24'hfffffd, 1);
		send_pair(KIND_CLEAR, 24'h123456, 24'hedcba9, 1);
		send_pair(KIND_CLEAR, 24'hffffff, 24'hffffff, 1);
		send_pair(KIND_SAMPLE, 24'h000000, 24'h7fffff, 0);
		wait_drained();

		for (int ph = 1; ph <= 10; ph++) begin
			phase_config(ph);
			if (ph == 4)
				long_stall_req++;
			sent = 0;
			run_left = 0;
			amp = 0;
			while (sent < 200) begin
				burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
				for (int b = 0; b < burst && sent < 200; b++) begin
					if (run_left == 0) begin
						run_left = $urandom_range(1, 60);
						amp = $urandom_range(0, 5);
					end
					run_left--;
					kind = ($urandom_range(0, 40) == 0) ? KIND_CLEAR : KIND_SAMPLE;
					send_pair(kind, sample_of(amp), sample_of(amp), b + 1 < burst);
					sent++;
				end
				s_axis_tvalid <= 1'b0;
				if ($urandom_range(0, 1))
					repeat ($urandom_range(1, 40)) @(posedge clk);
			end
			wait_drained();
		end

		if (fail_count == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
